// File: design/sffug_pkg.sv
// Shared types and codes for the stereo frame FIFO with underrun gate.
// Holds the transfer payload structs, the operation and result codes and fixed widths.
// No dependencies.
package sffug_pkg;

	localparam int FILL_W     = 11;
	localparam int SAMPLE_W   = 32;
	localparam int COUNT_IN_W = 7;
	localparam int OQ_DEPTH   = 4;
	localparam int OQ_LVL_W   = 3;

	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic [FILL_W-1:0] MIN_FILL_RESET = 11'd256;

	typedef struct packed {
		logic [1:0]            func;
		logic [SAMPLE_W-1:0]   left_sample;
		logic [SAMPLE_W-1:0]   right_sample;
		logic [COUNT_IN_W-1:0] read_count;
	} in_item_t;

	typedef struct packed {
		logic [1:0]          kind;
		logic                accepted;
		logic [SAMPLE_W-1:0] out_left;
		logic [SAMPLE_W-1:0] out_right;
		logic                silent;
		logic                last;
		logic [FILL_W-1:0]   fill_level;
	} out_item_t;

endpackage

// File: design/stereo_frame_fifo_underrun_gate_top.sv
// Top level of the stereo frame FIFO with underrun gate.
// Holds the output result queue and instantiates the sequencer.
// Depends on sffug_pkg and sffug_ctrl.
//
// Input channel (in_valid, in_stall, in_item) carries write, read and clear
// operations; the output channel (out_valid, out_stall, out_item) returns one
// result per write or clear and one frame per requested read frame, up to
// MAX_BLOCK frames. A write or clear result passes the result stage and then
// the queue. A read block holds the input stalled until its last frame is
// issued; its frames pass the frame store read and the result stage into the
// queue, one per cycle while the queue has room, paced by the single read
// port of the frame store. Writes and clears sustain one transfer per cycle
// while the receiver takes results. Results pass through a four-entry queue;
// when the receiver stalls the queue fills, after which the sequencer pauses
// and the input is stalled. Reset empties the FIFO and the queue and sets the
// minimum fill to 256. The minimum fill register is written through cfg_we and
// cfg_data; the user must write it only while idle; the block does not enforce it.
module stereo_frame_fifo_underrun_gate_top #(
	parameter int DEPTH     = 1024,
	parameter int MAX_BLOCK = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  sffug_pkg::in_item_t          in_item,
	output logic                         out_valid,
	input  logic                         out_stall,
	output sffug_pkg::out_item_t         out_item,
	input  logic                         cfg_we,
	input  logic [sffug_pkg::FILL_W-1:0] cfg_data
);

	import sffug_pkg::*;

	localparam int QA_W = $clog2(OQ_DEPTH);

	logic                push_valid;
	out_item_t           push_item;
	out_item_t           q_mem [OQ_DEPTH];
	logic [QA_W-1:0]     head_q;
	logic [QA_W-1:0]     tail_q;
	logic [OQ_LVL_W-1:0] level_q;
	logic                pop;

	sffug_ctrl #(
		.DEPTH    (DEPTH),
		.MAX_BLOCK(MAX_BLOCK)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.q_level   (level_q),
		.push_valid(push_valid),
		.push_item (push_item)
	);

	assign out_valid = level_q != '0;
	assign out_item  = q_mem[head_q];
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (push_valid) begin
			q_mem[tail_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			level_q <= '0;
		end else begin
			if (push_valid) begin
				tail_q <= tail_q + 1'b1;
			end
			if (pop) begin
				head_q <= head_q + 1'b1;
			end
			level_q <= level_q + OQ_LVL_W'(push_valid) - OQ_LVL_W'(pop);
		end
	end

endmodule

// File: design/sffug_ram.sv
// Frame store: simple dual-port synchronous RAM, one write and one read port.
// Read data is registered, so it appears in the cycle after the read is issued.
// No dependencies.
module sffug_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 64
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/sffug_ctrl.sv
// Sequencer for the frame FIFO: pointers, fill count, minimum-fill register and read blocks.
// Owns the frame store RAM and a result stage that merges the RAM read data.
// Depends on sffug_pkg and sffug_ram.
module sffug_ctrl #(
	parameter int DEPTH     = 1024,
	parameter int MAX_BLOCK = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  sffug_pkg::in_item_t           in_item,
	input  logic                          cfg_we,
	input  logic [sffug_pkg::FILL_W-1:0]  cfg_data,
	input  logic [sffug_pkg::OQ_LVL_W-1:0] q_level,
	output logic                          push_valid,
	output sffug_pkg::out_item_t          push_item
);

	import sffug_pkg::*;

	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int CMP_W = (CW > FILL_W) ? CW : FILL_W;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	logic                  state_q;
	logic [PW-1:0]         rptr_q;
	logic [PW-1:0]         wptr_q;
	logic [CW-1:0]         count_q;
	logic [COUNT_IN_W-1:0] rem_q;
	logic                  gated_q;
	logic [FILL_W-1:0]     min_fill_q;

	logic                  valid_s1;
	out_item_t             item_s1;
	logic                  from_ram_s1;

	logic                  room;
	logic                  accept;
	logic                  full;
	logic                  gate_now;
	logic                  take;
	logic [COUNT_IN_W-1:0] n_clamp;
	logic [PW-1:0]         rptr_inc;
	logic [PW-1:0]         wptr_inc;
	logic [CW-1:0]         ptr_gap;
	logic                  ram_we;
	logic [63:0]           ram_rdata;

	logic                  state_d;
	logic [PW-1:0]         rptr_d;
	logic [PW-1:0]         wptr_d;
	logic [CW-1:0]         count_d;
	logic [COUNT_IN_W-1:0] rem_d;
	logic                  gated_d;
	logic                  push_d;
	out_item_t             item_d;
	logic                  from_ram_d;

	assign room     = ({1'b0, q_level} + (OQ_LVL_W + 1)'(valid_s1)) < (OQ_LVL_W + 1)'(OQ_DEPTH);
	assign in_stall = !(state_q == ST_IDLE && room);
	assign accept   = in_valid && !in_stall;
	assign full     = count_q == CW'(DEPTH);
	assign gate_now = CMP_W'(count_q) < CMP_W'(min_fill_q);
	assign take     = state_q == ST_READ && room && !gated_q && count_q != '0;
	assign n_clamp  = (in_item.read_count > COUNT_IN_W'(MAX_BLOCK)) ?
		COUNT_IN_W'(MAX_BLOCK) : in_item.read_count;
	assign rptr_inc = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
	assign wptr_inc = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
	assign ram_we   = accept && in_item.func == FUNC_WRITE && !full;
	assign ptr_gap  = (wptr_q >= rptr_q) ? CW'(wptr_q) - CW'(rptr_q) :
		CW'(wptr_q) + CW'(DEPTH) - CW'(rptr_q);

	sffug_ram #(
		.DEPTH(DEPTH),
		.AW   (PW),
		.DW   (64)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wptr_q),
		.wdata({in_item.left_sample, in_item.right_sample}),
		.re   (take),
		.raddr(rptr_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d    = state_q;
		rptr_d     = rptr_q;
		wptr_d     = wptr_q;
		count_d    = count_q;
		rem_d      = rem_q;
		gated_d    = gated_q;
		push_d     = 1'b0;
		from_ram_d = 1'b0;
		item_d     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_item.func)
						FUNC_WRITE: begin
							if (!full) begin
								wptr_d  = wptr_inc;
								count_d = count_q + 1'b1;
							end
							push_d            = 1'b1;
							item_d.kind       = KIND_WRITE;
							item_d.accepted   = !full;
							item_d.last       = 1'b1;
							item_d.fill_level = FILL_W'(count_d);
						end
						FUNC_READ: begin
							if (n_clamp != '0) begin
								rem_d   = n_clamp;
								gated_d = gate_now;
								state_d = ST_READ;
							end
						end
						FUNC_CLEAR: begin
							rptr_d      = '0;
							wptr_d      = '0;
							count_d     = '0;
							push_d      = 1'b1;
							item_d.kind = KIND_CLEAR;
							item_d.last = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ST_READ: begin
				if (room) begin
					if (take) begin
						rptr_d  = rptr_inc;
						count_d = count_q - 1'b1;
					end
					rem_d             = rem_q - 1'b1;
					push_d            = 1'b1;
					from_ram_d        = take;
					item_d.kind       = KIND_READ;
					item_d.silent     = !take;
					item_d.last       = rem_q == COUNT_IN_W'(1);
					item_d.fill_level = FILL_W'(count_d);
					if (rem_q == COUNT_IN_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rptr_q     <= '0;
			wptr_q     <= '0;
			count_q    <= '0;
			rem_q      <= '0;
			gated_q    <= 1'b0;
			min_fill_q <= MIN_FILL_RESET;
			valid_s1   <= 1'b0;
		end else begin
			state_q  <= state_d;
			rptr_q   <= rptr_d;
			wptr_q   <= wptr_d;
			count_q  <= count_d;
			rem_q    <= rem_d;
			gated_q  <= gated_d;
			valid_s1 <= push_d;
			if (cfg_we) begin
				min_fill_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		item_s1     <= item_d;
		from_ram_s1 <= from_ram_d;
	end

	always_comb begin
		push_item = item_s1;
		if (from_ram_s1) begin
			push_item.out_left  = ram_rdata[63:32];
			push_item.out_right = ram_rdata[31:0];
		end
	end

	assign push_valid = valid_s1;

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q == ptr_gap || (count_q == CW'(DEPTH) && ptr_gap == '0))
		else $error("Fill count disagrees with the pointer distance.");

	assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= CMP_W'(DEPTH))
		else $error("Fill count exceeds the store depth.");

	assert property (@(posedge clk) disable iff (!arst_n)
		take |=> valid_s1 && from_ram_s1 && !item_s1.silent)
		else $error("A stored frame read did not reach the result stage.");

endmodule

// File: tb/sv/sffug_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the stereo frame FIFO testbench: it tracks the FIFO state and the results due.
// Depends on sffug_pkg for the transfer payload types and the operation and result codes.
package sffug_tb_pkg;
	import sffug_pkg::*;

	localparam int FIFO_DEPTH = 1024;
	localparam int BLOCK_MAX = 64;
	localparam int REPORT_MAX = 10;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	class frame_fifo_tracker;
		logic [63:0] frames [FIFO_DEPTH];
		logic [9:0] rd_ptr;
		logic [9:0] wr_ptr;
		logic [FILL_W-1:0] level;
		logic [FILL_W-1:0] min_fill;
		out_item_t due_results [$];
		int mismatches;

		function void clear_state();
			rd_ptr = '0;
			wr_ptr = '0;
			level = '0;
			min_fill = MIN_FILL_RESET;
			due_results.delete();
			mismatches = 0;
		endfunction

		function void set_min_fill(logic [FILL_W-1:0] v);
			min_fill = v;
		endfunction

		function int outstanding();
			return due_results.size();
		endfunction

		// Works out the results that one accepted input transfer causes.
		function void take_op(in_item_t op);
			out_item_t r;
			int n;
			int i;
			bit gated;
			logic [63:0] fr;
			r = '0;
			case (op.func)
				FUNC_WRITE: begin
					r.kind = KIND_WRITE;
					if (level < FIFO_DEPTH) begin
						frames[wr_ptr] = {op.left_sample, op.right_sample};
						wr_ptr = wr_ptr + 10'd1;
						level = level + 1'b1;
						r.accepted = 1'b1;
					end
					r.last = 1'b1;
					r.fill_level = level;
					due_results.push_back(r);
				end
				FUNC_READ: begin
					n = op.read_count;
					if (n > BLOCK_MAX)
						n = BLOCK_MAX;
					gated = (level < min_fill);
					for (i = 0; i < n; i++) begin
						r = '0;
						r.kind = KIND_READ;
						r.last = (i == n - 1);
						if (!gated && level != 0) begin
							fr = frames[rd_ptr];
							rd_ptr = rd_ptr + 10'd1;
							level = level - 1'b1;
							r.out_left = fr[63:32];
							r.out_right = fr[31:0];
						end else begin
							r.silent = 1'b1;
						end
						r.fill_level = level;
						due_results.push_back(r);
					end
				end
				FUNC_CLEAR: begin
					rd_ptr = '0;
					wr_ptr = '0;
					level = '0;
					r.kind = KIND_CLEAR;
					r.last = 1'b1;
					due_results.push_back(r);
				end
				default: begin
				end
			endcase
		endfunction

		// Compares one accepted output transfer with the oldest result due.
		function void match_result(out_item_t got);
			out_item_t want;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result: kind=%0d acc=%0b l=%h r=%h sil=%0b last=%0b fill=%0d",
						got.kind, got.accepted, got.out_left, got.out_right, got.silent,
						got.last, got.fill_level);
				return;
			end
			want = due_results.pop_front();
			if (got.kind !== want.kind || got.accepted !== want.accepted ||
					got.out_left !== want.out_left || got.out_right !== want.out_right ||
					got.silent !== want.silent || got.last !== want.last ||
					got.fill_level !== want.fill_level) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("mismatch: want kind=%0d acc=%0b l=%h r=%h sil=%0b last=%0b fill=%0d",
						want.kind, want.accepted, want.out_left, want.out_right, want.silent,
						want.last, want.fill_level);
					$display("          got  kind=%0d acc=%0b l=%h r=%h sil=%0b last=%0b fill=%0d",
						got.kind, got.accepted, got.out_left, got.out_right, got.silent,
						got.last, got.fill_level);
				end
			end
		endfunction
	endclass

endpackage

// File: tb/sv/tb_stereo_frame_fifo_underrun_gate_top.sv
`timescale 1ns / 1ps
// Top-level testbench for the stereo frame FIFO with underrun gate: directed and random stimulus.
// Depends on sffug_pkg, sffug_tb_pkg and the block stereo_frame_fifo_underrun_gate_top.
module tb_stereo_frame_fifo_underrun_gate_top;
	import sffug_pkg::*;
	import sffug_tb_pkg::*;

	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES = 300;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;
	logic cfg_we;
	logic [FILL_W-1:0] cfg_data;

	int tx_idle_pct;
	int rx_idle_pct;
	int hold_req;
	int hold_seen;
	frame_fifo_tracker board;

	stereo_frame_fifo_underrun_gate_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_seen + 1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) begin
					@(posedge clk);
					out_stall <= 1'b1;
				end
			end else begin
				out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.match_result(out_item);
	end

	function automatic in_item_t make_op(logic [1:0] f, logic [31:0] l, logic [31:0] r,
			logic [6:0] n);
		in_item_t op;
		op.func = f;
		op.left_sample = l;
		op.right_sample = r;
		op.read_count = n;
		return op;
	endfunction

	function automatic in_item_t random_op();
		in_item_t op;
		int pick;
		int sub;
		op = make_op(FUNC_WRITE, $urandom, $urandom, 7'($urandom));
		pick = $urandom_range(0, 99);
		sub = $urandom_range(0, 99);
		if (pick >= 50 && pick < 88) begin
			op.func = FUNC_READ;
			if (sub < 70)
				op.read_count = 7'($urandom_range(1, 8));
			else if (sub < 90)
				op.read_count = 7'($urandom_range(9, 64));
			else if (sub < 95)
				op.read_count = 7'($urandom_range(65, 127));
			else
				op.read_count = '0;
		end else if (pick >= 88 && pick < 94) begin
			op.func = FUNC_CLEAR;
		end else if (pick >= 94) begin
			op.func = FUNC_UNUSED;
		end
		return op;
	endfunction

	task automatic send_op(input in_item_t op);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= op;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.take_op(op);
	endtask

	task automatic wait_settled();
		in_valid <= 1'b0;
		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_min_fill(input logic [FILL_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_min_fill(v);
	endtask

	task automatic random_phase(input int count);
		in_item_t op;
		int done;
		done = 0;
		while (done < count) begin
			op = random_op();
			send_op(op);
			if (op.func != FUNC_UNUSED && !(op.func == FUNC_READ && op.read_count == 0))
				done++;
		end
	endtask

	initial begin
		int i;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_req = 0;
		board = new();
		board.clear_state();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, starting from the reset minimum fill.
		send_op(make_op(FUNC_READ, '0, '0, 7'd4));
		send_op(make_op(FUNC_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd0));
		send_op(make_op(FUNC_WRITE, 32'h0000_0000, 32'h0000_0000, 7'h7F));
		send_op(make_op(FUNC_WRITE, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 7'd3));
		send_op(make_op(FUNC_READ, '0, '0, 7'd2));
		send_op(make_op(FUNC_UNUSED, $urandom, $urandom, 7'd5));
		send_op(make_op(FUNC_READ, '0, '0, 7'd0));
		send_op(make_op(FUNC_CLEAR, '0, '0, 7'd0));
		wait_settled();
		write_min_fill('0);
		send_op(make_op(FUNC_WRITE, 32'hFFFF_FFFF, 32'h0000_0000, 7'd0));
		send_op(make_op(FUNC_WRITE, 32'h0000_0000, 32'hFFFF_FFFF, 7'd0));
		send_op(make_op(FUNC_WRITE, $urandom, $urandom, 7'd0));
		send_op(make_op(FUNC_READ, '0, '0, 7'd5));
		send_op(make_op(FUNC_READ, '0, '0, 7'd0));
		send_op(make_op(FUNC_READ, '0, '0, 7'd127));
		send_op(make_op(FUNC_WRITE, $urandom, $urandom, 7'd0));
		send_op(make_op(FUNC_READ, '0, '0, 7'd100));
		send_op(make_op(FUNC_UNUSED, $urandom, $urandom, 7'd64));
		send_op(make_op(FUNC_WRITE, $urandom, $urandom, 7'd0));
		send_op(make_op(FUNC_WRITE, $urandom, $urandom, 7'd0));
		send_op(make_op(FUNC_CLEAR, $urandom, $urandom, 7'd9));
		send_op(make_op(FUNC_READ, '0, '0, 7'd1));
		wait_settled();

		// Reads pass while the level is at or above the threshold and are gated once it drops below.
		write_min_fill(11'd8);
		for (i = 0; i < 10; i++)
			send_op(make_op(FUNC_WRITE, $urandom, $urandom, 7'd0));
		send_op(make_op(FUNC_READ, '0, '0, 7'd1));
		send_op(make_op(FUNC_READ, '0, '0, 7'd4));
		send_op(make_op(FUNC_READ, '0, '0, 7'd2));
		wait_settled();
		write_min_fill(11'd2047);
		send_op(make_op(FUNC_READ, '0, '0, 7'd3));
		wait_settled();
		write_min_fill('0);
		send_op(make_op(FUNC_READ, '0, '0, 7'd64));
		wait_settled();

		// Random part in three idling regimes.
		tx_idle_pct = 30;
		rx_idle_pct = 66;
		write_min_fill(11'($urandom_range(1, 12)));
		random_phase(50);
		wait_settled();
		tx_idle_pct = 66;
		rx_idle_pct = 30;
		write_min_fill(11'($urandom_range(0, 40)));
		random_phase(50);
		wait_settled();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_min_fill(11'd2);
		hold_req <= hold_req + 1;
		for (i = 0; i < 20; i++)
			send_op(make_op(FUNC_WRITE, $urandom, $urandom, 7'd0));
		random_phase(50);
		wait_settled();

		if (board.mismatches == 0 && board.outstanding() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
